// File: hw/rtl/tpsd_pkg.sv
package tpsd_pkg;

  localparam int ADDR_W          = 32;
  localparam int PORT_W          = 16;
  localparam int COUNT_W         = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int SLOTS_PER_PROTO = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int TRAP_PORTS_DEF  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BAN_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TCP_PORT_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TCP_PORT_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TCP_PORT_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_PORT_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_PORT_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_PORT_C    = 3'd6;

  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
  localparam logic [COUNT_W-1:0] BAN_THRESHOLD_RST = 16'd5;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic              trapped;
  } item_t;

endpackage

// File: hw/rtl/tpsd_intf.sv
interface tpsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [tpsd_pkg::ADDR_W-1:0] source_address;
  logic [tpsd_pkg::PORT_W-1:0] dest_port;
  logic                        is_udp;

  modport source (output valid, output source_address, output dest_port, output is_udp,
                  input ready);
  modport sink (input valid, input source_address, input dest_port, input is_udp,
                output ready);
endinterface

interface tpsd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         trapped;
  logic                         ban;
  logic [tpsd_pkg::ADDR_W-1:0]  banned_address;
  logic [tpsd_pkg::COUNT_W-1:0] hit_count;
  logic                         table_cleared;

  modport source (output valid, output trapped, output ban, output banned_address,
                  output hit_count, output table_cleared, input ready);
  modport sink (input valid, input trapped, input ban, input banned_address,
                input hit_count, input table_cleared, output ready);
endinterface

// File: hw/rtl/trap_port_scan_detector_core.sv
// Trap-port scan detector. Each packet header transfer is checked against up to
// three TCP and three UDP trap ports; a hit looks the source address up in a
// table of TABLE_DEPTH sources, which is searched one entry per cycle through
// its single read port. A header that hits no trap port goes from the queue
// straight to the registered result. A trapped header has the table read entry
// by entry until its source is found, whose count is then raised, or until the
// stored sources run out, when the source is added with a count of one. A
// two-entry queue lets headers keep arriving while a search runs and a result
// waits to be taken. When an addition fills the table, the table is emptied at
// once.
module trap_port_scan_detector_core #(
  parameter int TABLE_DEPTH = tpsd_pkg::TABLE_DEPTH_DEF,
  parameter int TRAP_PORTS  = tpsd_pkg::TRAP_PORTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tpsd_in_if.sink                         in_pkt,
  tpsd_out_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [tpsd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tpsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tpsd_pkg::*;

  logic [COUNT_W-1:0] ban_threshold;
  item_t              push_item;
  item_t              pop_item;
  logic               push;
  logic               not_full;
  logic               pop;
  logic               not_empty;

  tpsd_front #(
    .TRAP_PORTS (TRAP_PORTS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pkt        (in_pkt),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .ban_threshold (ban_threshold),
    .q_item        (push_item),
    .q_push        (push),
    .q_ready       (not_full)
  );

  tpsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .not_full  (not_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (not_empty)
  );

  tpsd_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (pop_item),
    .q_valid       (not_empty),
    .q_pop         (pop),
    .ban_threshold (ban_threshold),
    .out_res       (out_res)
  );

endmodule

// File: hw/rtl/tpsd_front.sv
module tpsd_front #(
  parameter int TRAP_PORTS = tpsd_pkg::TRAP_PORTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tpsd_in_if.sink                           in_pkt,
  input  logic                              cfg_we,
  input  logic [tpsd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tpsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [tpsd_pkg::COUNT_W-1:0]      ban_threshold,
  output tpsd_pkg::item_t                   q_item,
  output logic                              q_push,
  input  logic                              q_ready
);
  import tpsd_pkg::*;

  localparam int USED_SLOTS = (TRAP_PORTS < SLOTS_PER_PROTO) ? TRAP_PORTS : SLOTS_PER_PROTO;

  logic [COUNT_W-1:0] ban_threshold_r;
  logic [PORT_W-1:0]  tcp_port_r [SLOTS_PER_PROTO];
  logic [PORT_W-1:0]  udp_port_r [SLOTS_PER_PROTO];
  logic               port_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ban_threshold_r <= BAN_THRESHOLD_RST;
      for (int i = 0; i < SLOTS_PER_PROTO; i++) begin
        tcp_port_r[i] <= '0;
        udp_port_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BAN_THRESHOLD: ban_threshold_r <= cfg_wdata;
        REG_TCP_PORT_A:    tcp_port_r[0]   <= cfg_wdata;
        REG_TCP_PORT_B:    tcp_port_r[1]   <= cfg_wdata;
        REG_TCP_PORT_C:    tcp_port_r[2]   <= cfg_wdata;
        REG_UDP_PORT_A:    udp_port_r[0]   <= cfg_wdata;
        REG_UDP_PORT_B:    udp_port_r[1]   <= cfg_wdata;
        REG_UDP_PORT_C:    udp_port_r[2]   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // A slot holding zero is unused and never matches.
  always_comb begin
    logic [PORT_W-1:0] slot;
    port_hit = 1'b0;
    for (int i = 0; i < USED_SLOTS; i++) begin
      slot = in_pkt.is_udp ? udp_port_r[i] : tcp_port_r[i];
      if ((slot != '0) && (slot == in_pkt.dest_port)) begin
        port_hit = 1'b1;
      end
    end
  end

  assign in_pkt.ready          = q_ready;
  assign q_push                = in_pkt.valid && q_ready;
  assign q_item.source_address = in_pkt.source_address;
  assign q_item.trapped        = port_hit;
  assign ban_threshold         = ban_threshold_r;

endmodule

// File: hw/rtl/tpsd_queue.sv
module tpsd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tpsd_pkg::item_t push_item,
  output logic            not_full,
  input  logic            pop,
  output tpsd_pkg::item_t pop_item,
  output logic            not_empty
);
  import tpsd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [LVL_W-1:0]  level_r;
  logic              do_push;
  logic              do_pop;

  assign not_full  = (level_r != LVL_W'(QUEUE_DEPTH));
  assign not_empty = (level_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        level_r <= level_r + LVL_W'(1);
      end else if (do_pop && !do_push) begin
        level_r <= level_r - LVL_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/tpsd_back.sv
module tpsd_back #(
  parameter int TABLE_DEPTH = tpsd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpsd_pkg::item_t               q_item,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [tpsd_pkg::COUNT_W-1:0]  ban_threshold,
  tpsd_out_if.source                    out_res
);
  import tpsd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  source_address;
    logic [COUNT_W-1:0] count;
  } entry_t;

  entry_t             table_mem [TABLE_DEPTH];
  entry_t             rd_data_r;

  state_t             state_r;
  logic [CNT_W-1:0]   used_r;
  logic [CNT_W-1:0]   idx_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [ADDR_W-1:0]  src_r;

  logic               out_valid_r;
  logic               out_trapped_r;
  logic               out_ban_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_cleared_r;

  logic               out_free;
  logic               out_set;
  logic               issue_ok;
  logic               hit;
  logic               miss_done;
  logic [COUNT_W-1:0] inc_count;
  logic               ban_now;
  logic [CNT_W-1:0]   used_nxt;
  logic               table_full;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  assign out_free   = !out_valid_r || out_res.ready;
  assign q_pop      = (state_r == S_IDLE) && q_valid && out_free;
  assign issue_ok   = (state_r == S_SCAN) && (idx_r < used_r);
  assign hit        = (state_r == S_SCAN) && cmp_vld_r &&
                      (rd_data_r.source_address == src_r);
  assign miss_done  = (state_r == S_SCAN) && !cmp_vld_r && !issue_ok;
  assign out_set    = (q_pop && !q_item.trapped) || hit || miss_done;
  assign inc_count  = (rd_data_r.count == COUNT_MAX) ? COUNT_MAX
                                                     : rd_data_r.count + COUNT_W'(1);
  assign ban_now    = (inc_count >= ban_threshold);
  assign used_nxt   = used_r + CNT_W'(1);
  assign table_full = (used_nxt == CNT_W'(TABLE_DEPTH));

  assign wr_en   = hit || miss_done;
  assign wr_addr = hit ? cmp_idx_r : used_r[IDX_W-1:0];
  assign wr_data = hit ? entry_t'{src_r, inc_count} : entry_t'{src_r, COUNT_W'(1)};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= table_mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= issue_ok;
      cmp_idx_r <= idx_r[IDX_W-1:0];
      if (issue_ok) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            src_r <= q_item.source_address;
            if (q_item.trapped) begin
              idx_r   <= '0;
              state_r <= S_SCAN;
            end else begin
              out_trapped_r <= 1'b0;
              out_ban_r     <= 1'b0;
              out_addr_r    <= '0;
              out_count_r   <= '0;
              out_cleared_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            out_trapped_r <= 1'b1;
            out_ban_r     <= ban_now;
            out_addr_r    <= ban_now ? src_r : '0;
            out_count_r   <= inc_count;
            out_cleared_r <= 1'b0;
            state_r       <= S_IDLE;
          end else if (miss_done) begin
            out_trapped_r <= 1'b1;
            out_ban_r     <= 1'b0;
            out_addr_r    <= '0;
            out_count_r   <= COUNT_W'(1);
            out_cleared_r <= table_full;
            used_r        <= table_full ? '0 : used_nxt;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.trapped        = out_trapped_r;
  assign out_res.ban            = out_ban_r;
  assign out_res.banned_address = out_addr_r;
  assign out_res.hit_count      = out_count_r;
  assign out_res.table_cleared  = out_cleared_r;

endmodule
